// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the rtl control file bgu_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BGU_ASSERT_IMM(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BGU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bgu_pkg.sv =====
package bgu_pkg;

   // grid and number formats
   localparam int MAX_COARSE       = 64;
   localparam int COORD_W          = $clog2(MAX_COARSE);
   localparam int DEPTH            = MAX_COARSE * MAX_COARSE;
   localparam int ADDR_W           = 2 * COORD_W;
   localparam int FINE_W           = 12;
   localparam int SAMPLE_BITS      = 24;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int SPACING_W        = 9;
   localparam int SIZE_W           = 7;
   localparam int ENTRY_W          = 3 * SAMPLE_BITS;

   // weight generation widths
   localparam int SQ_W   = 2 * SPACING_W;
   localparam int CU_W   = SQ_W + SPACING_W;
   localparam int NUM_W  = 30;
   localparam int WQ_W   = 18;
   localparam int DVD_W  = NUM_W + WEIGHT_FRAC_BITS + 1;
   localparam int WREM_W = DVD_W - WQ_W;
   localparam int WGT_W  = WQ_W + 1;

   // accumulation widths
   localparam int PROD_W = SAMPLE_BITS + WGT_W;
   localparam int ROW_W  = PROD_W + 2;
   localparam int RND_W  = ROW_W - WEIGHT_FRAC_BITS + 1;
   localparam int TERM_W = RND_W + WGT_W;
   localparam int ACC_W  = TERM_W + 2;

   localparam int CNT_W = 5;
   localparam int IDX_W = 4;

   localparam logic signed [ACC_W-1:0] SAT_MAX =
      ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

   // register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = SPACING_W;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACING = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE    = 1'b1;
   localparam logic [SPACING_W-1:0] SPACING_RST = 9'd8;
   localparam logic [SIZE_W-1:0]    SIZE_RST    = 7'd16;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic                          mode;
      logic [COORD_W-1:0]            coarse_row;
      logic [COORD_W-1:0]            coarse_col;
      logic [FINE_W-1:0]             fine_i;
      logic [FINE_W-1:0]             fine_j;
      logic signed [SAMPLE_BITS-1:0] sample_x;
      logic signed [SAMPLE_BITS-1:0] sample_y;
      logic signed [SAMPLE_BITS-1:0] sample_z;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_x;
      logic signed [SAMPLE_BITS-1:0] out_y;
      logic signed [SAMPLE_BITS-1:0] out_z;
      logic                          inside_res;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_MUL1,
      ST_MUL2,
      ST_NUMER,
      ST_WINIT,
      ST_WDIV,
      ST_READ,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             write;
      logic             load;
      logic             div_step;
      logic             check;
      logic             mul1;
      logic             mul2;
      logic             numer;
      logic             winit;
      logic             wdiv_step;
      logic             issue;
      logic [IDX_W-1:0] rd_idx;
   } cmd_type;

   typedef struct packed {
      logic interior;
      logic acc_done;
   } sts_type;

   // divide by 2^frac, rounding half away from zero
   function automatic logic signed [ACC_W-1:0] round_frac(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] q;
      mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
      q   = (mag + (ACC_W'(1) << (WEIGHT_FRAC_BITS - 1))) >> WEIGHT_FRAC_BITS;
      return v[ACC_W-1] ? -$signed(q) : $signed(q);
   endfunction

endpackage

// ===== rtl/core/bgu_ctrl.sv =====
`include "assert_macros.svh"

module bgu_ctrl
   import bgu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_mode,
   input  logic    rsp_free,
   input  sts_type sts,
   output logic    req_stall,
   output logic    load_rsp,
   output cmd_type cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_mode == MODE_QUERY) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(FINE_W - 1)) state_in = ST_CHECK;
         end
         ST_CHECK:  state_in = ST_MUL1;
         ST_MUL1: begin
            state_in = sts.interior ? ST_MUL2 : ST_FINISH;
         end
         ST_MUL2:   state_in = ST_NUMER;
         ST_NUMER:  state_in = ST_WINIT;
         ST_WINIT:  state_in = ST_WDIV;
         ST_WDIV: begin
            if (cnt_ff == CNT_W'(WQ_W - 1)) state_in = ST_READ;
         end
         ST_READ: begin
            if (cnt_ff == CNT_W'((1 << IDX_W) - 1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (sts.acc_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // counter restarts on every state change
   always_comb begin
      cnt_in = (state_in != state_ff) ? '0 : cnt_ff + CNT_W'(1);
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.write = req_valid && req_mode == MODE_WRITE;
            cmd.load  = req_valid && req_mode == MODE_QUERY;
         end
         ST_DIV:    cmd.div_step = 1'b1;
         ST_CHECK:  cmd.check = 1'b1;
         ST_MUL1:   cmd.mul1 = 1'b1;
         ST_MUL2:   cmd.mul2 = 1'b1;
         ST_NUMER:  cmd.numer = 1'b1;
         ST_WINIT:  cmd.winit = 1'b1;
         ST_WDIV:   cmd.wdiv_step = 1'b1;
         ST_READ: begin
            cmd.issue  = 1'b1;
            cmd.rd_idx = cnt_ff[IDX_W-1:0];
         end
         ST_DRAIN:  cmd = '0;
         ST_FINISH: load_rsp = rsp_free;
         default:   cmd = '0;
      endcase
   end

   `BGU_ASSERT_IMM(a_done_in_drain, clock, reset, sts.acc_done, state_ff == ST_DRAIN, "accumulation finished outside drain")
   `BGU_ASSERT_IMM(a_load_free, clock, reset, load_rsp, rsp_free, "result loaded into an occupied output")
   `BGU_ASSERT_NXT(a_query_starts, clock, reset, cmd.load, state_ff == ST_DIV && cnt_ff == '0, "query did not start division")

endmodule

// ===== rtl/core/bgu_dp.sv =====
module bgu_dp
   import bgu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  req_type              req_data,
   input  logic [SPACING_W-1:0] spacing,
   input  logic [SIZE_W-1:0]    size,
   output sts_type              sts,
   output rsp_type              result
);

   typedef struct packed {
      logic       valid;
      logic [1:0] row;
      logic [1:0] col;
   } tag_type;

   logic [ENTRY_W-1:0] mem [DEPTH];

   logic [FINE_W-1:0]    dvd_ff [2];
   logic [SPACING_W-1:0] rem_ff [2];
   logic                 inside_ff;
   logic [SQ_W-1:0]      r2_ff [2];
   logic [SQ_W-1:0]      d2_ff;
   logic [CU_W-1:0]      r3_ff [2];
   logic [CU_W-1:0]      r2d_ff [2];
   logic [CU_W-1:0]      rd2_ff [2];
   logic [CU_W-1:0]      d3_ff;
   logic signed [NUM_W-1:0] num_ff [2][4];
   logic [WREM_W-1:0]    wrem_ff [2][4];
   logic [WQ_W-1:0]      wlo_ff [2][4];
   logic                 wneg_ff [2][4];
   logic signed [WGT_W-1:0] wgt [2][4];

   logic [ENTRY_W-1:0]         rd_data_ff;
   tag_type                    p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [PROD_W-1:0]   prod_ff [3];
   logic signed [ROW_W-1:0]    rowacc_ff [3];
   logic signed [RND_W-1:0]    rnd_ff [3];
   logic signed [TERM_W-1:0]   term_ff [3];
   logic signed [ACC_W-1:0]    acc_ff [3];
   logic                       done_ff;

   logic [COORD_W-1:0]   rd_row, rd_col;
   logic [SIZE_W-1:0]    size_sat;
   logic [FINE_W:0]      n_ext, m_ext;
   logic signed [SAMPLE_BITS-1:0] samp [3];
   logic signed [SAMPLE_BITS-1:0] fin [3];

   // coarse store, one write or one read per cycle
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[{req_data.coarse_row, req_data.coarse_col}] <=
            {req_data.sample_x, req_data.sample_y, req_data.sample_z};
      end
      if (cmd.issue) begin
         rd_data_ff <= mem[{rd_row, rd_col}];
      end
   end

   // cell division, one quotient bit per step on both axes
   always_ff @(posedge clock) begin
      logic [SPACING_W:0] t;
      for (int a = 0; a < 2; a++) begin
         if (cmd.load) begin
            dvd_ff[a] <= (a == 0) ? req_data.fine_i : req_data.fine_j;
            rem_ff[a] <= '0;
         end else if (cmd.div_step) begin
            t = {rem_ff[a], dvd_ff[a][FINE_W-1]};
            if (t >= {1'b0, spacing}) begin
               rem_ff[a] <= SPACING_W'(t - {1'b0, spacing});
               dvd_ff[a] <= {dvd_ff[a][FINE_W-2:0], 1'b1};
            end else begin
               rem_ff[a] <= t[SPACING_W-1:0];
               dvd_ff[a] <= {dvd_ff[a][FINE_W-2:0], 1'b0};
            end
         end
      end
   end

   // interior check
   always_comb begin
      size_sat = (size > SIZE_W'(MAX_COARSE)) ? SIZE_W'(MAX_COARSE) : size;
      n_ext    = {1'b0, dvd_ff[0]};
      m_ext    = {1'b0, dvd_ff[1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
      end else if (cmd.check) begin
         inside_ff <= (spacing != '0) && (dvd_ff[0] != '0) && (dvd_ff[1] != '0) &&
                      (n_ext + (FINE_W+1)'(3) <= (FINE_W+1)'(size_sat)) &&
                      (m_ext + (FINE_W+1)'(3) <= (FINE_W+1)'(size_sat));
      end
   end

   // powers of offset and spacing
   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         for (int a = 0; a < 2; a++) r2_ff[a] <= rem_ff[a] * rem_ff[a];
         d2_ff <= spacing * spacing;
      end
      if (cmd.mul2) begin
         for (int a = 0; a < 2; a++) begin
            r3_ff[a]  <= r2_ff[a] * rem_ff[a];
            r2d_ff[a] <= r2_ff[a] * spacing;
            rd2_ff[a] <= CU_W'(rem_ff[a]) * CU_W'(d2_ff);
         end
         d3_ff <= d2_ff * spacing;
      end
   end

   // cubic numerators over a common denominator of 2 d^3
   always_ff @(posedge clock) begin
      logic signed [NUM_W-1:0] r3s, r2ds, rd2s, d3s;
      if (cmd.numer) begin
         for (int a = 0; a < 2; a++) begin
            r3s  = $signed(NUM_W'(r3_ff[a]));
            r2ds = $signed(NUM_W'(r2d_ff[a]));
            rd2s = $signed(NUM_W'(rd2_ff[a]));
            d3s  = $signed(NUM_W'(d3_ff));
            num_ff[a][0] <= -r3s + (r2ds <<< 1) - rd2s;
            num_ff[a][1] <= NUM_W'(3) * r3s - NUM_W'(5) * r2ds + (d3s <<< 1);
            num_ff[a][2] <= -(NUM_W'(3) * r3s) + NUM_W'(4) * r2ds + rd2s;
            num_ff[a][3] <= r3s - r2ds;
         end
      end
   end

   // weight division, eight units side by side, one quotient bit per step
   always_ff @(posedge clock) begin
      logic [NUM_W-1:0]  mag;
      logic [DVD_W-1:0]  dividend;
      logic [WREM_W:0]   t;
      logic [WREM_W:0]   den;
      den = (WREM_W+1)'({d3_ff, 1'b0});
      for (int a = 0; a < 2; a++) begin
         for (int k = 0; k < 4; k++) begin
            if (cmd.winit) begin
               mag = num_ff[a][k][NUM_W-1] ? NUM_W'(-num_ff[a][k]) : NUM_W'(num_ff[a][k]);
               dividend = (DVD_W'(mag) << WEIGHT_FRAC_BITS) + DVD_W'(d3_ff);
               wrem_ff[a][k] <= dividend[DVD_W-1:WQ_W];
               wlo_ff[a][k]  <= dividend[WQ_W-1:0];
               wneg_ff[a][k] <= num_ff[a][k][NUM_W-1];
            end else if (cmd.wdiv_step) begin
               t = {wrem_ff[a][k], wlo_ff[a][k][WQ_W-1]};
               if (t >= den) begin
                  wrem_ff[a][k] <= WREM_W'(t - den);
                  wlo_ff[a][k]  <= {wlo_ff[a][k][WQ_W-2:0], 1'b1};
               end else begin
                  wrem_ff[a][k] <= WREM_W'(t);
                  wlo_ff[a][k]  <= {wlo_ff[a][k][WQ_W-2:0], 1'b0};
               end
            end
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         for (int k = 0; k < 4; k++) begin
            wgt[a][k] = wneg_ff[a][k] ? -$signed({1'b0, wlo_ff[a][k]})
                                      : $signed({1'b0, wlo_ff[a][k]});
         end
      end
   end

   // neighbourhood address, rows m-1..m+2 and columns n-1..n+2
   always_comb begin
      rd_row = dvd_ff[1][COORD_W-1:0] - COORD_W'(1) + COORD_W'(cmd.rd_idx[3:2]);
      rd_col = dvd_ff[0][COORD_W-1:0] - COORD_W'(1) + COORD_W'(cmd.rd_idx[1:0]);
      samp[0] = rd_data_ff[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
      samp[1] = rd_data_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];
      samp[2] = rd_data_ff[SAMPLE_BITS-1:0];
   end

   // pipeline tags
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff   <= '0;
         p2_ff   <= '0;
         p3_ff   <= '0;
         p4_ff   <= '0;
         p5_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         p1_ff   <= '{valid: cmd.issue, row: cmd.rd_idx[3:2], col: cmd.rd_idx[1:0]};
         p2_ff   <= p1_ff;
         p3_ff   <= '{valid: p2_ff.valid && p2_ff.col == 2'd3, row: p2_ff.row, col: p2_ff.col};
         p4_ff   <= p3_ff;
         p5_ff   <= p4_ff;
         done_ff <= p5_ff.valid && p5_ff.row == 2'd3;
      end
   end

   // column weighting, row sums, row rounding, row weighting and accumulation per component
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (p1_ff.valid) begin
            prod_ff[k] <= PROD_W'(samp[k]) * PROD_W'(wgt[0][p1_ff.col]);
         end
         if (p2_ff.valid) begin
            rowacc_ff[k] <= (p2_ff.col == 2'd0) ? ROW_W'(prod_ff[k])
                                                : rowacc_ff[k] + ROW_W'(prod_ff[k]);
         end
         if (p3_ff.valid) begin
            rnd_ff[k] <= RND_W'(round_frac(ACC_W'(rowacc_ff[k])));
         end
         if (p4_ff.valid) begin
            term_ff[k] <= TERM_W'(rnd_ff[k]) * TERM_W'(wgt[1][p4_ff.row]);
         end
         if (cmd.winit) begin
            acc_ff[k] <= '0;
         end else if (p5_ff.valid) begin
            acc_ff[k] <= acc_ff[k] + ACC_W'(term_ff[k]);
         end
      end
   end

   // final rounding and saturation
   always_comb begin
      logic signed [ACC_W-1:0] v;
      for (int k = 0; k < 3; k++) begin
         v = round_frac(acc_ff[k]);
         if (v > SAT_MAX)      fin[k] = SAT_MAX[SAMPLE_BITS-1:0];
         else if (v < SAT_MIN) fin[k] = SAT_MIN[SAMPLE_BITS-1:0];
         else                  fin[k] = v[SAMPLE_BITS-1:0];
      end
      result.out_x      = inside_ff ? fin[0] : '0;
      result.out_y      = inside_ff ? fin[1] : '0;
      result.out_z      = inside_ff ? fin[2] : '0;
      result.inside_res = inside_ff;
      sts.interior      = inside_ff;
      sts.acc_done      = done_ff;
   end

endmodule

// ===== rtl/core/bicubic_grid_upsampler.sv =====
// Catmull-Rom bicubic upsampler over a coarse grid of (x, y, z) samples.
// req channel (req_valid / req_stall / req_data): mode 0 stores one coarse
// sample, mode 1 queries one fine point (fine_i, fine_j).
// rsp channel (rsp_valid / rsp_stall / rsp_data): one transaction per query,
// none for a store. csr channel (csr_valid / csr_ready / csr_index /
// csr_wdata): index 0 cell spacing, index 1 coarse size; always ready.
// A store leaves req_stall low and the next transaction may follow at once.
// A query holds req_stall high for its whole run: cell division, set-up,
// weight division, 16 store reads at one read port and an accumulate drain,
// then rsp_valid rises and the next transaction can be taken in that same
// cycle. A point outside the interior skips weight division and the reads
// and returns zeros with inside_res low.
// The result sits in an output register: while rsp_stall holds it the next
// transaction is still accepted, and a query only waits at its last step.
// Reset clears control state and restores spacing 8 and size 16; the coarse
// store is not cleared and must be written before it is read.
module bicubic_grid_upsampler
   import bgu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [SPACING_W-1:0] spacing_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff;
   rsp_type              result;
   cmd_type              cmd;
   sts_type              sts;
   logic                 load_rsp;
   logic                 rsp_free;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= SPACING_RST;
         size_ff    <= SIZE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SPACING: spacing_ff <= csr_wdata;
            CSR_SIZE:    size_ff    <= csr_wdata[SIZE_W-1:0];
            default:     spacing_ff <= spacing_ff;
         endcase
      end
   end

   // output register
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bgu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .rsp_free  (rsp_free),
      .sts       (sts),
      .req_stall (req_stall),
      .load_rsp  (load_rsp),
      .cmd       (cmd)
   );

   bgu_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .spacing  (spacing_ff),
      .size     (size_ff),
      .sts      (sts),
      .result   (result)
   );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import bgu_pkg::*;

   localparam int RUN_LIMIT = 1500000;
   // rows and columns preloaded; every interior query at the reset size stays within them
   localparam int FILL = 20;

   // expected interpolation results and a private copy of grid and registers
   class grid_scoreboard;
      longint  spacing;
      longint  grid_size;
      longint  grid [64][64][3];
      rsp_type pending [$];
      int      errors;

      function new();
         spacing   = 8;
         grid_size = 16;
         errors    = 0;
      endfunction

      task report(input string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      // num * 2^frac / den, half away from zero
      function longint weight_quot(input longint num, input longint den);
         longint mag;
         longint q;
         mag = (num < 0) ? -num : num;
         q   = ((mag <<< WEIGHT_FRAC_BITS) + den / 2) / den;
         return (num < 0) ? -q : q;
      endfunction

      function longint drop_frac(input longint v);
         longint mag;
         longint q;
         mag = (v < 0) ? -v : v;
         q   = (mag + (64'sd1 <<< (WEIGHT_FRAC_BITS - 1))) >>> WEIGHT_FRAC_BITS;
         return (v < 0) ? -q : q;
      endfunction

      // four catmull-rom taps for offset r within a cell of d
      function void cubic_taps(input longint r, input longint d, output longint w [4]);
         longint r2;
         longint r3;
         longint d2;
         longint d3;
         r2 = r * r;
         r3 = r2 * r;
         d2 = d * d;
         d3 = d2 * d;
         w[0] = weight_quot(-r3 + 2 * r2 * d - r * d2, 2 * d3);
         w[1] = weight_quot(3 * r3 - 5 * r2 * d + 2 * d3, 2 * d3);
         w[2] = weight_quot(-3 * r3 + 4 * r2 * d + r * d2, 2 * d3);
         w[3] = weight_quot(r3 - r2 * d, 2 * d3);
      endfunction

      function void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
         if (idx == CSR_SPACING) spacing = v;
         else grid_size = v[SIZE_W-1:0];
      endfunction

      // accepted request transaction: update grid or queue the expected response, zeros outside the interior
      function void note(input req_type t);
         rsp_type e;
         longint  wx [4];
         longint  wy [4];
         longint  comp [3];
         longint  sz, n, m, acc, row_sum, v;
         if (t.mode == MODE_WRITE) begin
            grid[t.coarse_row][t.coarse_col][0] = t.sample_x;
            grid[t.coarse_row][t.coarse_col][1] = t.sample_y;
            grid[t.coarse_row][t.coarse_col][2] = t.sample_z;
            return;
         end
         e  = '0;
         sz = (grid_size > MAX_COARSE) ? MAX_COARSE : grid_size;
         if (spacing != 0) begin
            n = t.fine_i / spacing;
            m = t.fine_j / spacing;
            if (n >= 1 && m >= 1 && n + 3 <= sz && m + 3 <= sz) begin
               cubic_taps(t.fine_i - n * spacing, spacing, wx);
               cubic_taps(t.fine_j - m * spacing, spacing, wy);
               for (int k = 0; k < 3; k++) begin
                  acc = 0;
                  for (int r = 0; r < 4; r++) begin
                     row_sum = 0;
                     for (int c = 0; c < 4; c++)
                        row_sum += grid[m + r - 1][n + c - 1][k] * wx[c];
                     acc += drop_frac(row_sum) * wy[r];
                  end
                  v = drop_frac(acc);
                  if (v > 8388607) v = 8388607;
                  if (v < -8388608) v = -8388608;
                  comp[k] = v;
               end
               e.out_x      = 24'(comp[0]);
               e.out_y      = 24'(comp[1]);
               e.out_z      = 24'(comp[2]);
               e.inside_res = 1'b1;
            end
         end
         pending.push_back(e);
      endfunction

      task check(input rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            report("response transaction with nothing outstanding");
            return;
         end
         e = pending.pop_front();
         if (got.out_x !== e.out_x)
            report($sformatf("out_x %0d, expected %0d", got.out_x, e.out_x));
         if (got.out_y !== e.out_y)
            report($sformatf("out_y %0d, expected %0d", got.out_y, e.out_y));
         if (got.out_z !== e.out_z)
            report($sformatf("out_z %0d, expected %0d", got.out_z, e.out_z));
         if (got.inside_res !== e.inside_res)
            report($sformatf("inside_res %0b, expected %0b", got.inside_res, e.inside_res));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   grid_scoreboard sb;
   int             idle_pct;
   int             stall_pct;
   longint         cycles;

   bicubic_grid_upsampler uut (.*);

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // response side back-pressure
   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   // check each response transaction, sampled mid-cycle
   always @(negedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_data);

   task send(input req_type t);
      bit ok;
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do begin
         @(negedge clock);
         ok = !req_stall;
         @(posedge clock);
      end while (!ok);
      sb.note(t);
   endtask

   // hold off until every expected response has come, then let the block settle
   task drain;
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      bit ok;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      csr_valid <= 1'b0;
      @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   function logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return '0;
         default: return 24'($urandom);
      endcase
   endfunction

   task store_sample(input int r, input int c, input logic [SAMPLE_BITS-1:0] x,
                     input logic [SAMPLE_BITS-1:0] y, input logic [SAMPLE_BITS-1:0] z);
      req_type      t;
      logic [127:0] raw;
      raw          = {$urandom, $urandom, $urandom, $urandom};
      t            = raw[$bits(req_type)-1:0];
      t.mode       = MODE_WRITE;
      t.coarse_row = 6'(r);
      t.coarse_col = 6'(c);
      t.sample_x   = x;
      t.sample_y   = y;
      t.sample_z   = z;
      send(t);
   endtask

   task query(input int fi, input int fj);
      req_type      t;
      logic [127:0] raw;
      raw      = {$urandom, $urandom, $urandom, $urandom};
      t        = raw[$bits(req_type)-1:0];
      t.mode   = MODE_QUERY;
      t.fine_i = 12'(fi);
      t.fine_j = 12'(fj);
      send(t);
   endtask

   // a fine coordinate whose cell lies in the interior, or a random one when there is no interior
   function int aimed_coord();
      longint d;
      longint sz;
      longint top;
      longint n;
      d   = sb.spacing;
      sz  = (sb.grid_size > MAX_COARSE) ? MAX_COARSE : sb.grid_size;
      top = sz - 3;
      if (d != 0 && (4095 / d) < top) top = 4095 / d;
      if (d == 0 || top < 1) return $urandom_range(0, 4095);
      n = $urandom_range(1, top);
      if (n * d + d - 1 > 4095) return int'(n * d);
      return int'(n * d + $urandom_range(0, d - 1));
   endfunction

   int phase_spacing [8] = '{1, 256, 0, 511, 3, 5, 2, 256};
   int phase_size    [8] = '{4, 64, 16, 127, 20, 10, 4, 100};
   int sent;

   initial begin
      sb        = new();
      cycles    = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_SPACING;
      csr_wdata = '0;
      idle_pct  = 6;
      stall_pct = 51;
      sent      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // preload every entry that an interior query at the reset size can reach
      for (int r = 0; r < FILL; r++)
         for (int c = 0; c < FILL; c++)
            store_sample(r, c, pick_sample(), pick_sample(), pick_sample());

      // overshoot block: two high columns between two low ones forces saturation
      for (int r = 4; r < 8; r++)
         for (int c = 4; c < 8; c++)
            store_sample(r, c, (c == 5 || c == 6) ? 24'h7FFFFF : 24'h800000,
                         (c == 5 || c == 6) ? 24'h800000 : 24'h7FFFFF, 24'h000001);
      query(44, 44);
      // interior corners, edges just outside, coordinate extremes
      query(8, 8);
      query(111, 111);
      query(112, 8);
      query(8, 7);
      query(0, 0);
      query(4095, 4095);
      drain();

      for (int p = 0; p < 8; p++) begin
         write_reg(CSR_SPACING, 9'(phase_spacing[p]));
         write_reg(CSR_SIZE, 9'(phase_size[p]));
         for (int k = 0; k < 185; k++) begin
            if (sent < 210) begin
               idle_pct  = 6;
               stall_pct = 51;
            end else if (sent < 845) begin
               idle_pct  = 51;
               stall_pct = 6;
            end else begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            if (p == 2 && k == 120) drain();
            if ($urandom_range(0, 9) < 3)
               store_sample($urandom_range(0, 63), $urandom_range(0, 63),
                            pick_sample(), pick_sample(), pick_sample());
            else if ($urandom_range(0, 9) < 8)
               query(aimed_coord(), aimed_coord());
            else
               query($urandom_range(0, 4095), $urandom_range(0, 4095));
            sent++;
         end
         drain();
      end

      // registers back to their reset values
      write_reg(CSR_SPACING, 9'd8);
      write_reg(CSR_SIZE, 9'd16);
      query(60, 70);
      drain();

      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
